// File: hw/rtl/bba_pkg.sv
// Shared types, constants and helper functions for the buddy block allocator.
// Depends on nothing; bba_ctrl, bba_dpath and the top level refer to it by scoped names.
package bba_pkg;

	localparam int ORDER    = 10;
	localparam int TOTAL    = 1 << ORDER;
	localparam int NODE_W   = ORDER + 1;          // heap index of a tree node
	localparam int ROW_IW   = 5;                  // bit index inside a map row
	localparam int ROW_BITS = 1 << ROW_IW;
	localparam int ROW_AW   = NODE_W - ROW_IW;    // map row address
	localparam int ROWS     = 1 << ROW_AW;
	localparam int LV_W     = 4;                  // level, up to 12 for oversize requests
	localparam int SIZE_W   = 12;
	localparam int ADDR_W   = 11;
	localparam int BADDR_W  = ORDER;
	localparam int LEN_W    = ORDER + 1;
	localparam int CNT_W    = ORDER + 1;

	typedef enum logic [2:0] {
		ST_ALLOC_OK  = 3'd0,
		ST_BAD_REQ   = 3'd1,
		ST_FRAG      = 3'd2,
		ST_SHORT     = 3'd3,
		ST_FREE_OK   = 3'd4,
		ST_BAD_RANGE = 3'd5,
		ST_NOT_ALLOC = 3'd6,
		ST_NO_BLOCK  = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		RD_SCAN,
		RD_SPLIT,
		RD_DES
	} rd_sel_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SPLIT_RD,
		S_SPLIT_WR,
		S_USE_RD,
		S_USE_WR,
		S_CHK_RD,
		S_CHK,
		S_MRG_RD,
		S_MRG_CHK,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic    clr_step;
		logic    load;
		logic    scan_init;
		logic    scan_adv;
		logic    scan_take;
		logic    split_wr;
		logic    use_wr;
		logic    chk_ok;
		logic    mrg_merge;
		logic    mrg_stop;
		logic    set_status;
		logic    out_load;
		status_t status;
		rd_sel_t rd_sel;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_free;
		logic size_zero;
		logic lv_over;
		logic range_bad;
		logic misaligned;
		logic scan_hit;
		logic row_last;
		logic k_last;
		logic k_gt_lv;
		logic split_last;
		logic frag;
		logic free_bit;
		logic used_bit;
		logic merge_hit;
		logic out_busy;
	} stat_t;

	// smallest lv with 2^lv >= n
	function automatic logic [LV_W-1:0] level_for(input logic [SIZE_W-1:0] n);
		logic [SIZE_W-1:0] m;
		logic [LV_W-1:0]   lv;
		m  = n - SIZE_W'(1);
		lv = '0;
		if (n > SIZE_W'(1)) begin
			for (int i = 0; i < SIZE_W; i++) begin
				if (m[i]) lv = LV_W'(i + 1);
			end
		end
		return lv;
	endfunction

	// heap index of the block at level lv starting at unit a (lv <= ORDER)
	function automatic logic [NODE_W-1:0] node_of(input logic [LV_W-1:0] lv,
			input logic [ORDER-1:0] a);
		logic [NODE_W-1:0] base;
		logic [NODE_W-1:0] off;
		base = NODE_W'(1) << (LV_W'(ORDER) - lv);
		off  = NODE_W'(a) >> lv;
		return base | off;
	endfunction

endpackage

// File: hw/rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the block maps and the requested-size store.
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/bba_ctrl.sv
// Sequencing state machine of the buddy allocator.
// Depends on bba_pkg; drives bba_dpath through cmd_t and reads stat_t.
module bba_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  bba_pkg::stat_t stat,
	input  logic           in_valid,
	output logic           in_ready,
	output bba_pkg::cmd_t  cmd
);

	bba_pkg::state_t state_q;
	bba_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.status = bba_pkg::ST_ALLOC_OK;
		cmd.rd_sel = bba_pkg::RD_DES;
		in_ready   = 1'b0;
		case (state_q)
			bba_pkg::S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) state_d = bba_pkg::S_IDLE;
			end
			bba_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = bba_pkg::S_DECODE;
				end
			end
			bba_pkg::S_DECODE: begin
				if (!stat.is_free) begin
					if (stat.size_zero) begin
						cmd.set_status = 1'b1;
						cmd.status     = bba_pkg::ST_BAD_REQ;
						state_d        = bba_pkg::S_RESULT;
					end else if (stat.lv_over) begin
						cmd.set_status = 1'b1;
						cmd.status     = stat.frag ? bba_pkg::ST_FRAG : bba_pkg::ST_SHORT;
						state_d        = bba_pkg::S_RESULT;
					end else begin
						cmd.scan_init = 1'b1;
						state_d       = bba_pkg::S_SCAN_RD;
					end
				end else begin
					if (stat.range_bad) begin
						cmd.set_status = 1'b1;
						cmd.status     = bba_pkg::ST_BAD_RANGE;
						state_d        = bba_pkg::S_RESULT;
					end else if (stat.lv_over || stat.misaligned) begin
						cmd.set_status = 1'b1;
						cmd.status     = bba_pkg::ST_NO_BLOCK;
						state_d        = bba_pkg::S_RESULT;
					end else begin
						state_d = bba_pkg::S_CHK_RD;
					end
				end
			end
			bba_pkg::S_SCAN_RD: begin
				cmd.rd_sel = bba_pkg::RD_SCAN;
				state_d    = bba_pkg::S_SCAN_CHK;
			end
			bba_pkg::S_SCAN_CHK: begin
				if (stat.scan_hit) begin
					cmd.scan_take = 1'b1;
					state_d = stat.k_gt_lv ? bba_pkg::S_SPLIT_RD : bba_pkg::S_USE_RD;
				end else if (stat.row_last && stat.k_last) begin
					cmd.set_status = 1'b1;
					cmd.status     = stat.frag ? bba_pkg::ST_FRAG : bba_pkg::ST_SHORT;
					state_d        = bba_pkg::S_RESULT;
				end else begin
					cmd.scan_adv = 1'b1;
					state_d      = bba_pkg::S_SCAN_RD;
				end
			end
			bba_pkg::S_SPLIT_RD: begin
				cmd.rd_sel = bba_pkg::RD_SPLIT;
				state_d    = bba_pkg::S_SPLIT_WR;
			end
			bba_pkg::S_SPLIT_WR: begin
				cmd.split_wr = 1'b1;
				state_d = stat.split_last ? bba_pkg::S_USE_RD : bba_pkg::S_SPLIT_RD;
			end
			bba_pkg::S_USE_RD: begin
				state_d = bba_pkg::S_USE_WR;
			end
			bba_pkg::S_USE_WR: begin
				cmd.use_wr     = 1'b1;
				cmd.set_status = 1'b1;
				cmd.status     = bba_pkg::ST_ALLOC_OK;
				state_d        = bba_pkg::S_RESULT;
			end
			bba_pkg::S_CHK_RD: begin
				state_d = bba_pkg::S_CHK;
			end
			bba_pkg::S_CHK: begin
				if (stat.free_bit) begin
					cmd.set_status = 1'b1;
					cmd.status     = bba_pkg::ST_NOT_ALLOC;
					state_d        = bba_pkg::S_RESULT;
				end else if (!stat.used_bit) begin
					cmd.set_status = 1'b1;
					cmd.status     = bba_pkg::ST_NO_BLOCK;
					state_d        = bba_pkg::S_RESULT;
				end else begin
					cmd.chk_ok = 1'b1;
					state_d    = bba_pkg::S_MRG_RD;
				end
			end
			bba_pkg::S_MRG_RD: begin
				state_d = bba_pkg::S_MRG_CHK;
			end
			bba_pkg::S_MRG_CHK: begin
				if (stat.merge_hit) begin
					cmd.mrg_merge = 1'b1;
					state_d       = bba_pkg::S_MRG_RD;
				end else begin
					cmd.mrg_stop   = 1'b1;
					cmd.set_status = 1'b1;
					cmd.status     = bba_pkg::ST_FREE_OK;
					state_d        = bba_pkg::S_RESULT;
				end
			end
			bba_pkg::S_RESULT: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = bba_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bba_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// File: hw/rtl/bba_dpath.sv
// Datapath of the buddy allocator: block maps, size store, counters, result register.
// Depends on bba_pkg and bba_ram; commanded by bba_ctrl.
module bba_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bba_pkg::cmd_t                  cmd,
	output bba_pkg::stat_t                 stat,
	input  logic                           in_mode,
	input  logic [bba_pkg::SIZE_W-1:0]     in_size,
	input  logic [bba_pkg::ADDR_W-1:0]     in_address,
	output logic                           out_valid,
	input  logic                           out_ready,
	output bba_pkg::status_t               out_status,
	output logic [bba_pkg::BADDR_W-1:0]    out_block_address,
	output logic [bba_pkg::LEN_W-1:0]      out_block_length,
	output logic [bba_pkg::CNT_W-1:0]      out_free_units
);

	localparam int LO_W  = bba_pkg::NODE_W + 1;
	localparam int SUM_W = bba_pkg::SIZE_W + 1;

	// request and walk registers
	logic                          mode_q;
	logic [bba_pkg::SIZE_W-1:0]    size_q;
	logic [bba_pkg::ADDR_W-1:0]    addr_q;
	logic [bba_pkg::LV_W-1:0]      lv_q;
	logic [bba_pkg::LV_W-1:0]      k_q;
	logic [bba_pkg::LV_W-1:0]      j_q;
	logic [bba_pkg::ROW_AW-1:0]    row_q;
	logic [bba_pkg::ORDER-1:0]     des_q;
	bba_pkg::status_t              status_q;
	// control state
	logic [bba_pkg::ROW_AW-1:0]    clr_q;
	logic [bba_pkg::CNT_W-1:0]     alloc_q;
	logic                          out_valid_q;
	// result register
	bba_pkg::status_t              out_status_q;
	logic [bba_pkg::BADDR_W-1:0]   out_baddr_q;
	logic [bba_pkg::LEN_W-1:0]     out_blen_q;
	logic [bba_pkg::CNT_W-1:0]     out_free_q;

	// memories
	logic                          free_we, used_we;
	logic [bba_pkg::ROW_AW-1:0]    free_waddr, used_waddr, raddr;
	logic [bba_pkg::ROW_BITS-1:0]  free_wdata, used_wdata, free_rdata, used_rdata;
	logic [bba_pkg::CNT_W-1:0]     req_rdata;

	// combinational helpers
	logic [LO_W-1:0]               lo, hi;
	logic [bba_pkg::ROW_AW-1:0]    hi_row;
	logic [bba_pkg::ROW_BITS-1:0]  hits;
	logic [bba_pkg::ROW_IW-1:0]    pe;
	logic [bba_pkg::NODE_W-1:0]    found, off, start_w, split_node, des_node;
	logic [bba_pkg::ROW_IW-1:0]    des_bit, bud_bit;
	logic [bba_pkg::CNT_W-1:0]     free_cnt;
	logic [SUM_W-1:0]              end_sum, add_sum;
	logic [bba_pkg::ADDR_W-1:0]    align_mask;

	function automatic logic [bba_pkg::ROW_AW-1:0] lo_row_of(
			input logic [bba_pkg::LV_W-1:0] k);
		logic [bba_pkg::NODE_W-1:0] l;
		l = bba_pkg::NODE_W'(1) << (bba_pkg::LV_W'(bba_pkg::ORDER) - k);
		return l[bba_pkg::ROW_IW +: bba_pkg::ROW_AW];
	endfunction

	// level range in heap order and row scan
	always_comb begin
		lo     = LO_W'(1) << (bba_pkg::LV_W'(bba_pkg::ORDER) - k_q);
		hi     = (lo << 1) - LO_W'(1);
		hi_row = hi[bba_pkg::ROW_IW +: bba_pkg::ROW_AW];
		for (int b = 0; b < bba_pkg::ROW_BITS; b++) begin
			hits[b] = free_rdata[b]
				&& (LO_W'({row_q, bba_pkg::ROW_IW'(b)}) >= lo)
				&& (LO_W'({row_q, bba_pkg::ROW_IW'(b)}) <= hi);
		end
		pe = '0;
		for (int b = bba_pkg::ROW_BITS - 1; b >= 0; b--) begin
			if (hits[b]) pe = bba_pkg::ROW_IW'(b);
		end
		found   = {row_q, pe};
		off     = found & (lo[bba_pkg::NODE_W-1:0] - bba_pkg::NODE_W'(1));
		start_w = off << k_q;
	end

	assign split_node = bba_pkg::node_of(j_q, des_q | (bba_pkg::ORDER'(1) << j_q));
	assign des_node   = bba_pkg::node_of(lv_q, des_q);
	assign des_bit    = des_node[bba_pkg::ROW_IW-1:0];
	assign bud_bit    = des_bit ^ bba_pkg::ROW_IW'(1);

	always_comb begin
		case (cmd.rd_sel)
			bba_pkg::RD_SCAN:  raddr = row_q;
			bba_pkg::RD_SPLIT: raddr = split_node[bba_pkg::ROW_IW +: bba_pkg::ROW_AW];
			bba_pkg::RD_DES:   raddr = des_node[bba_pkg::ROW_IW +: bba_pkg::ROW_AW];
			default:           raddr = row_q;
		endcase
	end

	// free map writes
	always_comb begin
		free_we    = 1'b0;
		free_waddr = des_node[bba_pkg::ROW_IW +: bba_pkg::ROW_AW];
		free_wdata = free_rdata;
		if (cmd.clr_step) begin
			free_we    = 1'b1;
			free_waddr = clr_q;
			// root node sits at row 0, bit 1
			free_wdata = (clr_q == '0) ? bba_pkg::ROW_BITS'(2) : '0;
		end else if (cmd.scan_take) begin
			free_we    = 1'b1;
			free_waddr = row_q;
			free_wdata = free_rdata & ~(bba_pkg::ROW_BITS'(1) << pe);
		end else if (cmd.split_wr) begin
			free_we    = 1'b1;
			free_waddr = split_node[bba_pkg::ROW_IW +: bba_pkg::ROW_AW];
			free_wdata = free_rdata
				| (bba_pkg::ROW_BITS'(1) << split_node[bba_pkg::ROW_IW-1:0]);
		end else if (cmd.mrg_merge) begin
			free_we    = 1'b1;
			free_wdata = free_rdata & ~(bba_pkg::ROW_BITS'(1) << bud_bit);
		end else if (cmd.mrg_stop) begin
			free_we    = 1'b1;
			free_wdata = free_rdata | (bba_pkg::ROW_BITS'(1) << des_bit);
		end
	end

	// used map writes
	always_comb begin
		used_we    = 1'b0;
		used_waddr = des_node[bba_pkg::ROW_IW +: bba_pkg::ROW_AW];
		used_wdata = used_rdata;
		if (cmd.clr_step) begin
			used_we    = 1'b1;
			used_waddr = clr_q;
			used_wdata = '0;
		end else if (cmd.use_wr) begin
			used_we    = 1'b1;
			used_wdata = used_rdata | (bba_pkg::ROW_BITS'(1) << des_bit);
		end else if (cmd.chk_ok) begin
			used_we    = 1'b1;
			used_wdata = used_rdata & ~(bba_pkg::ROW_BITS'(1) << des_bit);
		end
	end

	bba_ram #(.WIDTH(bba_pkg::ROW_BITS), .DEPTH(bba_pkg::ROWS)) u_free_map (
		.clk   (clk),
		.we    (free_we),
		.waddr (free_waddr),
		.wdata (free_wdata),
		.raddr (raddr),
		.rdata (free_rdata)
	);

	bba_ram #(.WIDTH(bba_pkg::ROW_BITS), .DEPTH(bba_pkg::ROWS)) u_used_map (
		.clk   (clk),
		.we    (used_we),
		.waddr (used_waddr),
		.wdata (used_wdata),
		.raddr (raddr),
		.rdata (used_rdata)
	);

	// size store only ever written on a successful allocate, so size fits CNT_W
	bba_ram #(.WIDTH(bba_pkg::CNT_W), .DEPTH(bba_pkg::TOTAL)) u_req_store (
		.clk   (clk),
		.we    (cmd.use_wr),
		.waddr (des_q),
		.wdata (size_q[bba_pkg::CNT_W-1:0]),
		.raddr (des_q),
		.rdata (req_rdata)
	);

	assign free_cnt   = bba_pkg::CNT_W'(bba_pkg::TOTAL) - alloc_q;
	assign end_sum    = SUM_W'(addr_q) + SUM_W'(size_q);
	assign add_sum    = SUM_W'(alloc_q) + SUM_W'(size_q);
	assign align_mask = (bba_pkg::ADDR_W'(1) << lv_q) - bba_pkg::ADDR_W'(1);

	always_comb begin
		stat            = '0;
		stat.clr_last   = (clr_q == bba_pkg::ROW_AW'(bba_pkg::ROWS - 1));
		stat.is_free    = mode_q;
		stat.size_zero  = (size_q == '0);
		stat.lv_over    = (lv_q > bba_pkg::LV_W'(bba_pkg::ORDER));
		stat.range_bad  = (size_q == '0) || (end_sum > SUM_W'(bba_pkg::TOTAL));
		stat.misaligned = ((addr_q & align_mask) != '0);
		stat.scan_hit   = (hits != '0);
		stat.row_last   = (row_q == hi_row);
		stat.k_last     = (k_q == bba_pkg::LV_W'(bba_pkg::ORDER));
		stat.k_gt_lv    = (k_q > lv_q);
		stat.split_last = (bba_pkg::LV_W'(j_q + bba_pkg::LV_W'(1)) == k_q);
		stat.frag       = (bba_pkg::SIZE_W'(free_cnt) > size_q);
		stat.free_bit   = free_rdata[des_bit];
		stat.used_bit   = used_rdata[des_bit];
		stat.merge_hit  = (lv_q < bba_pkg::LV_W'(bba_pkg::ORDER)) && free_rdata[bud_bit];
		stat.out_busy   = out_valid_q && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			alloc_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + bba_pkg::ROW_AW'(1);
			if (cmd.use_wr) begin
				alloc_q <= (add_sum > SUM_W'(bba_pkg::TOTAL)) ?
					bba_pkg::CNT_W'(bba_pkg::TOTAL) : add_sum[bba_pkg::CNT_W-1:0];
			end else if (cmd.chk_ok) begin
				alloc_q <= (alloc_q >= req_rdata) ? alloc_q - req_rdata : '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			size_q <= in_size;
			addr_q <= in_address;
			lv_q   <= bba_pkg::level_for(in_size);
			des_q  <= in_address[bba_pkg::ORDER-1:0];
		end
		if (cmd.scan_init) begin
			k_q   <= lv_q;
			row_q <= lo_row_of(lv_q);
		end
		if (cmd.scan_adv) begin
			if (row_q == hi_row) begin
				k_q   <= k_q + bba_pkg::LV_W'(1);
				row_q <= lo_row_of(k_q + bba_pkg::LV_W'(1));
			end else begin
				row_q <= row_q + bba_pkg::ROW_AW'(1);
			end
		end
		if (cmd.scan_take) begin
			des_q <= start_w[bba_pkg::ORDER-1:0];
			j_q   <= lv_q;
		end
		if (cmd.split_wr) j_q <= j_q + bba_pkg::LV_W'(1);
		if (cmd.mrg_merge) begin
			des_q <= des_q & ~(bba_pkg::ORDER'(1) << lv_q);
			lv_q  <= lv_q + bba_pkg::LV_W'(1);
		end
		if (cmd.set_status) status_q <= cmd.status;
		if (cmd.out_load) begin
			out_status_q <= status_q;
			out_free_q   <= free_cnt;
			if (status_q == bba_pkg::ST_ALLOC_OK) begin
				out_baddr_q <= des_q;
				out_blen_q  <= bba_pkg::LEN_W'(1) << lv_q;
			end else begin
				out_baddr_q <= '0;
				out_blen_q  <= '0;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign out_status        = out_status_q;
	assign out_block_address = out_baddr_q;
	assign out_block_length  = out_blen_q;
	assign out_free_units    = out_free_q;

`ifndef NO_ASSERTIONS
	a_alloc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_q <= bba_pkg::CNT_W'(bba_pkg::TOTAL))
		else $error("allocated count beyond capacity");

	a_take_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_take |-> stat.scan_hit)
		else $error("block taken from an empty scan row");

	a_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && !out_ready))
		else $error("result overwritten while still pending");

	a_fail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != bba_pkg::ST_ALLOC_OK)
			|-> (out_baddr_q == '0 && out_blen_q == '0))
		else $error("block fields set on a non-allocation result");
`endif

endmodule

// File: hw/rtl/buddy_block_allocator_core.sv
// Top level of the binary buddy allocator: stream ports and result packing.
// Depends on bba_pkg, bba_ctrl, bba_dpath (and bba_ram through the datapath).
//
// Use: one request per item on the s_axis channel. tuser is the mode (0 allocate,
// 1 free); tdata carries the size and, for a free, the start unit. Each request
// yields exactly one result on m_axis: tuser is the status code, tdata the
// block start, the power-of-two block length and the free unit count.
// After reset a clearing pass sweeps the 64 rows of both block maps, one row a
// cycle; s_axis_tready stays low during the pass, then only the root is free.
// Requests are handled one at a time. An allocate reads and checks the map rows
// scanned (up to 68 over all levels, through the single read port of the free
// map), then splits the levels above the request's level. A free checks the
// block, then does its buddy merges.
// The result sits in an output register; the next request is accepted while it
// waits, and only the finishing of that next request stalls behind a held
// m_axis_tready.
module buddy_block_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [11:0] size, [22:12] address, [23] zero
	input  logic [0:0]  s_axis_tuser,   // [0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [9:0] block_address, [20:10] block_length,
	                                    // [31:21] free_units
	output logic [2:0]  m_axis_tuser    // [2:0] status
);

	bba_pkg::cmd_t                   cmd;
	bba_pkg::stat_t                  stat;
	bba_pkg::status_t                res_status;
	logic [bba_pkg::BADDR_W-1:0]     res_baddr;
	logic [bba_pkg::LEN_W-1:0]       res_blen;
	logic [bba_pkg::CNT_W-1:0]       res_free;

	// sequencer
	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd)
	);

	// maps, counters and result register
	bba_dpath u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.in_mode           (s_axis_tuser[0]),
		.in_size           (s_axis_tdata[11:0]),
		.in_address        (s_axis_tdata[22:12]),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.out_status        (res_status),
		.out_block_address (res_baddr),
		.out_block_length  (res_blen),
		.out_free_units    (res_free)
	);

	assign m_axis_tdata = {res_free, res_blen, res_baddr};
	assign m_axis_tuser = res_status;

endmodule
